### rtl/eavm_pkg.sv
package eavm_pkg;

   localparam int CordicSteps = 16;
   localparam int ZW = 21;   // q16 angle after widening
   localparam int XW = 20;   // cordic x/y range
   localparam logic signed [ZW-1:0] QPi     = 21'sd205887;
   localparam logic signed [ZW-1:0] QTwoPi  = 21'sd411775;
   localparam logic signed [ZW-1:0] QHalfPi = 21'sd102944;
   localparam logic signed [XW-1:0] CordicGain = 20'sd39797;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [15:0] angle_x;
      logic signed [15:0] angle_y;
      logic signed [15:0] angle_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] right_x;
      logic signed [15:0] right_y;
      logic signed [15:0] right_z;
      logic signed [15:0] up_x;
      logic signed [15:0] up_y;
      logic signed [15:0] up_z;
      logic signed [15:0] fwd_x;
      logic signed [15:0] fwd_y;
      logic signed [15:0] fwd_z;
      logic signed [31:0] trans_u;
      logic signed [31:0] trans_v;
      logic signed [31:0] trans_w;
   } rsp_type;

   // one cordic lane: rotation state for one angle
   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
      logic                 flip;
   } lane_type;

   typedef lane_type [2:0] lanes_type;

   function automatic logic signed [ZW-1:0] atan_q16(input int i);
      logic signed [ZW-1:0] r;
      case (i)
         0: r = 21'sd51472;
         1: r = 21'sd30386;
         2: r = 21'sd16055;
         3: r = 21'sd8150;
         4: r = 21'sd4091;
         5: r = 21'sd2047;
         6: r = 21'sd1024;
         7: r = 21'sd512;
         8: r = 21'sd256;
         9: r = 21'sd128;
         10: r = 21'sd64;
         11: r = 21'sd32;
         12: r = 21'sd16;
         13: r = 21'sd8;
         14: r = 21'sd4;
         15: r = 21'sd2;
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic signed [15:0] clamp14(input logic signed [63:0] v);
      logic signed [15:0] r;
      if (v > 64'sd16384) r = 16'sd16384;
      else if (v < -64'sd16384) r = -16'sd16384;
      else r = v[15:0];
      return r;
   endfunction

endpackage

### rtl/eavm_stream_if.sv
interface eavm_stream_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### rtl/eavm_cordic_cell.sv
// one micro-rotation for all three angles; hands its result to the next cell
module eavm_cordic_cell #(
   parameter int Step = 0
) (
   input  logic                 clock,
   input  logic                 enable,
   input  eavm_pkg::lanes_type  lanes_in,
   output eavm_pkg::lanes_type  lanes_out
);
   eavm_pkg::lanes_type lanes_ff, lanes_step_in;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         lanes_step_in[k].flip = lanes_in[k].flip;
         if (lanes_in[k].z >= 0) begin
            lanes_step_in[k].x = lanes_in[k].x - (lanes_in[k].y >>> Step);
            lanes_step_in[k].y = lanes_in[k].y + (lanes_in[k].x >>> Step);
            lanes_step_in[k].z = lanes_in[k].z - eavm_pkg::atan_q16(Step);
         end else begin
            lanes_step_in[k].x = lanes_in[k].x + (lanes_in[k].y >>> Step);
            lanes_step_in[k].y = lanes_in[k].y - (lanes_in[k].x >>> Step);
            lanes_step_in[k].z = lanes_in[k].z + eavm_pkg::atan_q16(Step);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) lanes_ff <= lanes_step_in;
   end

   assign lanes_out = lanes_ff;
endmodule

### rtl/euler_angle_view_matrix.sv
// channel | dir | handshake              | payload
// req     | in  | req_valid / req_ready  | position q16.16, angles q4.12
// rsp     | out | rsp_valid / rsp_ready  | basis q2.14, translation q16.16
//
// one reduction stage, sixteen cordic cells, six sign-fix, multiply/sum
// and saturate stages; a new item may enter every cycle unless stalled.
// the pipeline advances as one: it stalls only when the last stage holds
// an item that the sink has not taken (rsp_ready low).
// reset (synchronous) clears the valid bits only.
module euler_angle_view_matrix (
   input logic clock,
   input logic reset,
   eavm_stream_if.sink   req,
   eavm_stream_if.source rsp
);
   localparam int NS = eavm_pkg::CordicSteps;
   localparam int Depth = NS + 7;

   logic [Depth-1:0] vld_ff;
   logic             adv;

   // whole pipe moves when the output slot is free or being taken
   assign adv = !vld_ff[Depth-1] || rsp.ready;
   assign req.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[Depth-2:0], req.valid};
      end
   end

   // position rides alongside the cordic, up to the basis-times-position stage
   logic signed [31:0] px_ff [NS+4], py_ff [NS+4], pz_ff [NS+4];
   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff[0] <= req.data.pos_x;
         py_ff[0] <= req.data.pos_y;
         pz_ff[0] <= req.data.pos_z;
         for (int i = 1; i < NS + 4; i++) begin
            px_ff[i] <= px_ff[i-1];
            py_ff[i] <= py_ff[i-1];
            pz_ff[i] <= pz_ff[i-1];
         end
      end
   end

   // range reduction into [-pi/2, pi/2]
   eavm_pkg::lanes_type red_in, red_ff;
   logic signed [15:0] ang [3];
   assign ang[0] = req.data.angle_x;
   assign ang[1] = req.data.angle_y;
   assign ang[2] = req.data.angle_z;

   always_comb begin
      logic signed [eavm_pkg::ZW-1:0] z;
      for (int k = 0; k < 3; k++) begin
         z = {{(eavm_pkg::ZW-20){ang[k][15]}}, ang[k], 4'b0};
         if (z > eavm_pkg::QPi) z = z - eavm_pkg::QTwoPi;
         else if (z < -eavm_pkg::QPi) z = z + eavm_pkg::QTwoPi;
         red_in[k].flip = 1'b0;
         if (z > eavm_pkg::QHalfPi) begin
            z = z - eavm_pkg::QPi;
            red_in[k].flip = 1'b1;
         end else if (z < -eavm_pkg::QHalfPi) begin
            z = z + eavm_pkg::QPi;
            red_in[k].flip = 1'b1;
         end
         red_in[k].z = z;
         red_in[k].x = eavm_pkg::CordicGain;
         red_in[k].y = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) red_ff <= red_in;
   end

   // chain of cordic cells
   eavm_pkg::lanes_type chain [NS+1];
   assign chain[0] = red_ff;
   for (genvar g = 0; g < NS; g++) begin : g_cell
      eavm_cordic_cell #(.Step(g)) u_cell (
         .clock(clock), .enable(adv), .lanes_in(chain[g]), .lanes_out(chain[g+1])
      );
   end

   // sign fix and q14 conversion
   logic signed [15:0] s_ff [3], c_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            logic signed [eavm_pkg::XW:0] xv, yv;
            xv = chain[NS][k].flip ? -{chain[NS][k].x[eavm_pkg::XW-1], chain[NS][k].x}
                                   : {chain[NS][k].x[eavm_pkg::XW-1], chain[NS][k].x};
            yv = chain[NS][k].flip ? -{chain[NS][k].y[eavm_pkg::XW-1], chain[NS][k].y}
                                   : {chain[NS][k].y[eavm_pkg::XW-1], chain[NS][k].y};
            c_ff[k] <= eavm_pkg::clamp14(64'(((xv + 21'sd2) >>> 2)));
            s_ff[k] <= eavm_pkg::clamp14(64'(((yv + 21'sd2) >>> 2)));
         end
      end
   end

   // index 0: pitch (2), 1: yaw (1), 2: roll (3)
   logic signed [15:0] s1, c1, s2, c2, s3, c3;
   assign s2 = s_ff[0]; assign c2 = c_ff[0];
   assign s1 = s_ff[1]; assign c1 = c_ff[1];
   assign s3 = s_ff[2]; assign c3 = c_ff[2];

   // stage a: pair products (q28)
   logic signed [31:0] c1c3_ff, s1s2_ff, c1s2_ff, c3s1_ff, c1s3_ff, s1s3_ff;
   logic signed [31:0] c2s3_ff, c2c3_ff, c2s1_ff, c1c2_ff;
   logic signed [15:0] s3a_ff, c3a_ff, s2a_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         c1c3_ff <= c1 * c3; s1s2_ff <= s1 * s2; c1s2_ff <= c1 * s2;
         c3s1_ff <= c3 * s1; c1s3_ff <= c1 * s3; s1s3_ff <= s1 * s3;
         c2s3_ff <= c2 * s3; c2c3_ff <= c2 * c3; c2s1_ff <= c2 * s1;
         c1c2_ff <= c1 * c2;
         s3a_ff <= s3; c3a_ff <= c3; s2a_ff <= s2;
      end
   end

   // stage b: triple products and sums (q42), rounded to q14
   logic signed [15:0] b_ff [9];
   always_ff @(posedge clock) begin
      if (adv) begin
         logic signed [63:0] t [9];
         t[0] = 64'(c1c3_ff) * 64'sd16384 + 64'(s1s2_ff) * 64'(s3a_ff);
         t[1] = 64'(c2s3_ff) * 64'sd16384;
         t[2] = 64'(c1s2_ff) * 64'(s3a_ff) - 64'(c3s1_ff) * 64'sd16384;
         t[3] = 64'(s1s2_ff) * 64'(c3a_ff) - 64'(c1s3_ff) * 64'sd16384;
         t[4] = 64'(c2c3_ff) * 64'sd16384;
         t[5] = 64'(c1s2_ff) * 64'(c3a_ff) + 64'(s1s3_ff) * 64'sd16384;
         t[6] = 64'(c2s1_ff) * 64'sd16384;
         t[7] = -64'(s2a_ff) * 64'sd268435456;
         t[8] = 64'(c1c2_ff) * 64'sd16384;
         for (int k = 0; k < 9; k++)
            b_ff[k] <= eavm_pkg::clamp14((t[k] + 64'sd134217728) >>> 28);
      end
   end

   // stage c: basis times position (q30)
   logic signed [47:0] pr_ff [9];
   logic signed [15:0] bc_ff [9];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int r = 0; r < 3; r++) begin
            pr_ff[3*r]   <= 48'(b_ff[3*r])   * 48'(px_ff[NS+3]);
            pr_ff[3*r+1] <= 48'(b_ff[3*r+1]) * 48'(py_ff[NS+3]);
            pr_ff[3*r+2] <= 48'(b_ff[3*r+2]) * 48'(pz_ff[NS+3]);
         end
         bc_ff <= b_ff;
      end
   end

   // stage d: sum, negate, round
   logic signed [49:0] dt_ff [3];
   logic signed [15:0] bd_ff [9];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int r = 0; r < 3; r++)
            dt_ff[r] <= (-(50'(pr_ff[3*r]) + 50'(pr_ff[3*r+1]) + 50'(pr_ff[3*r+2]))
                         + 50'sd8192) >>> 14;
         bd_ff <= bc_ff;
      end
   end

   // stage e: saturate into output register
   eavm_pkg::rsp_type out_ff;
   logic signed [31:0] tr [3];
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         if (dt_ff[r] > 50'sd2147483647) tr[r] = 32'sh7fffffff;
         else if (dt_ff[r] < -50'sd2147483648) tr[r] = 32'sh80000000;
         else tr[r] = dt_ff[r][31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff.right_x <= bd_ff[0]; out_ff.right_y <= bd_ff[1]; out_ff.right_z <= bd_ff[2];
         out_ff.up_x    <= bd_ff[3]; out_ff.up_y    <= bd_ff[4]; out_ff.up_z    <= bd_ff[5];
         out_ff.fwd_x   <= bd_ff[6]; out_ff.fwd_y   <= bd_ff[7]; out_ff.fwd_z   <= bd_ff[8];
         out_ff.trans_u <= tr[0]; out_ff.trans_v <= tr[1]; out_ff.trans_w <= tr[2];
      end
   end

   assign rsp.valid = vld_ff[Depth-1];
   assign rsp.data  = out_ff;

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(out_ff))
      else $error("output changed while stalled");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp.valid |-> req.ready)
      else $error("input blocked with empty output");
   a_basis: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> out_ff.fwd_y <= 16'sd16384 && out_ff.fwd_y >= -16'sd16384)
      else $error("basis term out of range");
endmodule

### sim/euler_angle_view_matrix_tb.sv
`timescale 1ns / 1ps

module euler_angle_view_matrix_tb;

   localparam int LatencyCycles = 23;
   localparam int WatchdogLimit = 4000;
   localparam int RandomPoses = 800;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   eavm_stream_if #(.payload_type(eavm_pkg::req_type)) req_if (.clock(clock));
   eavm_stream_if #(.payload_type(eavm_pkg::rsp_type)) rsp_if (.clock(clock));

   euler_angle_view_matrix u_dut (
      .clock(clock),
      .reset(reset),
      .req(req_if.sink),
      .rsp(rsp_if.source)
   );

   // expected view matrices, oldest first
   eavm_pkg::rsp_type pending_views[$];
   int error_count = 0;
   int idle_cycles = 0;
   bit stimulus_done = 1'b0;

   // cordic arctangent table in q16
   function automatic longint atan_step(input int i);
      longint atab[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                           256, 128, 64, 32, 16, 8, 4, 2};
      return atab[i];
   endfunction

   // >>> on a signed longint is an arithmetic (floor) shift
   function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // sine and cosine in q14 of a q4.12 angle
   task automatic angle_trig(input logic signed [15:0] ang, output longint s,
                             output longint c);
      longint z, x, y, nx;
      bit flip;
      z = longint'(ang) * 16;
      x = 39797;
      y = 0;
      flip = 1'b0;
      if (z > 205887) z -= 411775;
      else if (z < -205887) z += 411775;
      if (z > 102944) begin
         z -= 205887;
         flip = 1'b1;
      end else if (z < -102944) begin
         z += 205887;
         flip = 1'b1;
      end
      for (int i = 0; i < 16; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= atan_step(i);
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += atan_step(i);
         end
         x = nx;
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      c = clamp_to((x + 2) >>> 2, -16384, 16384);
      s = clamp_to((y + 2) >>> 2, -16384, 16384);
   endtask

   function automatic longint round_basis(input longint sum_q42);
      return clamp_to((sum_q42 + (64'sd1 <<< 27)) >>> 28, -16384, 16384);
   endfunction

   function automatic logic signed [31:0] translation_term(input longint b0, input longint b1,
         input longint b2, input eavm_pkg::req_type p);
      longint dot, r;
      dot = b0 * longint'(p.pos_x) + b1 * longint'(p.pos_y) + b2 * longint'(p.pos_z);
      r = (-dot + (64'sd1 <<< 13)) >>> 14;
      return 32'(clamp_to(r, -64'sd2147483648, 64'sd2147483647));
   endfunction

   // yxz basis and translation of one camera pose
   task automatic predict_view(input eavm_pkg::req_type p, output eavm_pkg::rsp_type m);
      longint s1, c1, s2, c2, s3, c3;
      longint u[3], v[3], w[3];
      angle_trig(p.angle_x, s2, c2);
      angle_trig(p.angle_y, s1, c1);
      angle_trig(p.angle_z, s3, c3);
      u[0] = round_basis(c1 * c3 * 16384 + s1 * s2 * s3);
      u[1] = round_basis(c2 * s3 * 16384);
      u[2] = round_basis(c1 * s2 * s3 - c3 * s1 * 16384);
      v[0] = round_basis(c3 * s1 * s2 - c1 * s3 * 16384);
      v[1] = round_basis(c2 * c3 * 16384);
      v[2] = round_basis(c1 * c3 * s2 + s1 * s3 * 16384);
      w[0] = round_basis(c2 * s1 * 16384);
      w[1] = round_basis(-s2 * 16384 * 16384);
      w[2] = round_basis(c1 * c2 * 16384);
      m.right_x = 16'(u[0]);
      m.right_y = 16'(u[1]);
      m.right_z = 16'(u[2]);
      m.up_x = 16'(v[0]);
      m.up_y = 16'(v[1]);
      m.up_z = 16'(v[2]);
      m.fwd_x = 16'(w[0]);
      m.fwd_y = 16'(w[1]);
      m.fwd_z = 16'(w[2]);
      m.trans_u = translation_term(u[0], u[1], u[2], p);
      m.trans_v = translation_term(v[0], v[1], v[2], p);
      m.trans_w = translation_term(w[0], w[1], w[2], p);
   endtask

   // directed poses; has_view marks rows with a hand-read expectation
   typedef struct {
      eavm_pkg::req_type pose;
      bit                has_view;
      eavm_pkg::rsp_type view;
   } pose_row_type;

   // zero angles: the cordic leaves sine at one lsb, so the basis is
   // identity plus single-lsb cross terms
   localparam eavm_pkg::rsp_type ZeroAngleView =
      '{16384, 1, -1, -1, 16384, 1, 1, -1, 16384, 0, 0, 0};

   pose_row_type pose_table[$];

   function automatic eavm_pkg::req_type make_pose(input logic signed [31:0] px,
         input logic signed [31:0] py, input logic signed [31:0] pz,
         input logic signed [15:0] ax, input logic signed [15:0] ay,
         input logic signed [15:0] az);
      eavm_pkg::req_type p;
      p = '{px, py, pz, ax, ay, az};
      return p;
   endfunction

   function automatic eavm_pkg::req_type random_pose();
      eavm_pkg::req_type p;
      p.pos_x = $urandom;
      p.pos_y = $urandom;
      p.pos_z = $urandom;
      // mostly small positions so the translation is not always saturated
      if ($urandom_range(0, 2) != 0) begin
         p.pos_x = $signed(p.pos_x) >>> $urandom_range(4, 24);
         p.pos_y = $signed(p.pos_y) >>> $urandom_range(4, 24);
         p.pos_z = $signed(p.pos_z) >>> $urandom_range(4, 24);
      end
      p.angle_x = $urandom;
      p.angle_y = $urandom;
      p.angle_z = $urandom;
      return p;
   endfunction

   initial begin
      pose_row_type row;
      // zero pose: near-identity basis, no translation
      row = '{make_pose(0, 0, 0, 0, 0, 0), 1'b1, ZeroAngleView};
      pose_table.push_back(row);
      // zero angles with position extremes: translation saturates for the negative one
      row.pose = make_pose(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 0);
      row.view = ZeroAngleView;
      row.view.trans_u = 32'sh7fff_ffff;
      row.view.trans_v = 32'sh7fff_ffff;
      row.view.trans_w = 32'sh7fff_ffff;
      pose_table.push_back(row);
      row.pose = make_pose(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 0, 0, 0);
      row.view = ZeroAngleView;
      row.view.trans_u = -32'sh7fff_ffff;
      row.view.trans_v = -32'sh7fff_ffff;
      row.view.trans_w = -32'sh7fff_ffff;
      pose_table.push_back(row);
      row.has_view = 1'b0;
      // small position with zero angles
      row.pose = make_pose(32'sh0001_0000, -32'sh0002_0000, 32'sh0003_0000, 0, 0, 0);
      pose_table.push_back(row);
      // angle extremes on each axis, near pi, near half pi, and mixed
      row.pose = make_pose(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 16'sh7fff, 0, 0);
      pose_table.push_back(row);
      row.pose = make_pose(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 0, 16'sh8000, 0);
      pose_table.push_back(row);
      row.pose = make_pose(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 0, 0, 16'sh7fff);
      pose_table.push_back(row);
      row.pose = make_pose(0, 0, 0, 16'sh8000, 16'sh8000, 16'sh8000);
      pose_table.push_back(row);
      row.pose = make_pose(0, 0, 0, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      pose_table.push_back(row);
      row.pose = make_pose(32'sh0010_0000, 0, 0, 12868, -12868, 12868);
      pose_table.push_back(row);
      row.pose = make_pose(0, 32'sh0010_0000, 0, 12869, 12867, -12869);
      pose_table.push_back(row);
      row.pose = make_pose(0, 0, 32'sh0010_0000, 6434, 6435, -6434);
      pose_table.push_back(row);
      row.pose = make_pose(0, 0, 32'sh0010_0000, -6435, -6434, 6435);
      pose_table.push_back(row);
      row.pose = make_pose(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 3217, 9000, -20000);
      pose_table.push_back(row);
      row.pose = make_pose(32'shffff_ffff, 1, -1, 1, -1, 1);
      pose_table.push_back(row);
   end

   // source side: walks the table, then random poses in bursts
   task automatic send_pose(input eavm_pkg::req_type p);
      req_if.valid <= 1'b1;
      req_if.data <= p;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic take_gap(input int n);
      req_if.valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   initial begin
      int burst;
      req_if.valid = 1'b0;
      req_if.data = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (pose_table[i]) begin
         send_pose(pose_table[i].pose);
         if ($urandom_range(0, 3) == 0) take_gap($urandom_range(1, 3));
      end
      // let the directed part drain before the random part
      take_gap(1);
      while (pending_views.size() != 0) @(posedge clock);
      for (int n = 0; n < RandomPoses; ) begin
         burst = $urandom_range(1, 40);
         for (int b = 0; b < burst && n < RandomPoses; b++, n++) send_pose(random_pose());
         if ($urandom_range(0, 2) != 0) take_gap($urandom_range(1, 8));
      end
      req_if.valid <= 1'b0;
      stimulus_done = 1'b1;
   end

   // predictions are queued at acceptance, in order
   always @(posedge clock) begin
      eavm_pkg::rsp_type m;
      if (!reset && req_if.valid && req_if.ready) begin
         predict_view(req_if.data, m);
         pending_views.push_back(m);
      end
   end

   // sink side: stall pattern of its own, with quiet stretches
   initial begin
      int phase;
      rsp_if.ready = 1'b0;
      phase = 0;
      forever begin
         @(posedge clock);
         phase++;
         if ((phase / 200) % 3 == 0) rsp_if.ready <= 1'b1;
         else if ((phase / 200) % 3 == 1) rsp_if.ready <= ($urandom_range(0, 3) != 0);
         else rsp_if.ready <= ((phase % 7) < 3);
      end
   end

   // compare every accepted view matrix with the oldest prediction
   always @(posedge clock) begin
      eavm_pkg::rsp_type e, a;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         a = rsp_if.data;
         if (pending_views.size() == 0) begin
            $error("view matrix with no pose waiting");
            error_count++;
         end else begin
            e = pending_views.pop_front();
            if (a.right_x !== e.right_x) begin
               $error("right_x expected %0d got %0d", e.right_x, a.right_x); error_count++;
            end
            if (a.right_y !== e.right_y) begin
               $error("right_y expected %0d got %0d", e.right_y, a.right_y); error_count++;
            end
            if (a.right_z !== e.right_z) begin
               $error("right_z expected %0d got %0d", e.right_z, a.right_z); error_count++;
            end
            if (a.up_x !== e.up_x) begin
               $error("up_x expected %0d got %0d", e.up_x, a.up_x); error_count++;
            end
            if (a.up_y !== e.up_y) begin
               $error("up_y expected %0d got %0d", e.up_y, a.up_y); error_count++;
            end
            if (a.up_z !== e.up_z) begin
               $error("up_z expected %0d got %0d", e.up_z, a.up_z); error_count++;
            end
            if (a.fwd_x !== e.fwd_x) begin
               $error("fwd_x expected %0d got %0d", e.fwd_x, a.fwd_x); error_count++;
            end
            if (a.fwd_y !== e.fwd_y) begin
               $error("fwd_y expected %0d got %0d", e.fwd_y, a.fwd_y); error_count++;
            end
            if (a.fwd_z !== e.fwd_z) begin
               $error("fwd_z expected %0d got %0d", e.fwd_z, a.fwd_z); error_count++;
            end
            if (a.trans_u !== e.trans_u) begin
               $error("trans_u expected %0d got %0d", e.trans_u, a.trans_u); error_count++;
            end
            if (a.trans_v !== e.trans_v) begin
               $error("trans_v expected %0d got %0d", e.trans_v, a.trans_v); error_count++;
            end
            if (a.trans_w !== e.trans_w) begin
               $error("trans_w expected %0d got %0d", e.trans_w, a.trans_w); error_count++;
            end
         end
      end
   end

   // hand-read rows: the predictor must agree with the typed-in view
   initial begin
      eavm_pkg::rsp_type m;
      #1;
      foreach (pose_table[i]) begin
         if (pose_table[i].has_view) begin
            predict_view(pose_table[i].pose, m);
            if (m !== pose_table[i].view) begin
               $error("directed row %0d: view expected %h got %h", i,
                      pose_table[i].view, m);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles without any accepted item, then the end of the run
   initial begin
      forever begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WatchdogLimit) begin
            $display("DONE: errors detected");
            $finish;
         end
         if (stimulus_done && pending_views.size() == 0) begin
            repeat (LatencyCycles + 5) @(posedge clock);
            if (rsp_if.valid) begin
               $error("view matrix left over after the last pose");
               error_count++;
            end
            if (error_count == 0) $display("DONE: 0 errors");
            else $display("DONE: errors detected");
            $finish;
         end
      end
   end

endmodule
